// ===== hdl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  // Width of the byte held in the transmit shift register.
  localparam int ByteW  = 8;
  localparam int MsbPos = ByteW - 1;

  // Stream word widths; the tdata widths are filled up to whole bytes.
  localparam int InDataW  = 16;
  localparam int InUserW  = 2;
  localparam int OutDataW = 8;
  localparam int OutFieldW = 4;

  // Command codes carried in tuser.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  // Sequencer states, one per command plus idle.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WRITE,
    ST_ACK,
    ST_STOP
  } state_e;

  // Step within one data bit of a write.
  typedef enum logic [1:0] {
    BIT_HIGH,
    BIT_LOW,
    BIT_LOAD
  } bit_step_e;

  // Control from the sequencer to the shift register.
  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctrl_t;

  // One pin phase result; the last field sits in the lowest bit.
  typedef struct packed {
    logic last;
    logic nack;
    logic sda_drive;
    logic sda_level;
    logic scl_level;
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/i2cms_shifter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_shifter (
  input  wire logic                    clk_i,
  input  wire i2cms_pkg::shift_ctrl_t  ctrl_i,
  input  wire logic [i2cms_pkg::ByteW-1:0] data_byte_i,
  output logic                         msb_o
);
  import i2cms_pkg::*;

  logic [ByteW-1:0] shift_q;
  logic [ByteW-1:0] shift_d;

  // Load a new byte or move it up by one bit, filling with zeros.
  always_comb begin
    shift_d = shift_q;
    if (ctrl_i.load) begin
      shift_d = data_byte_i;
    end else if (ctrl_i.shift) begin
      shift_d = {shift_q[MsbPos-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign msb_o = shift_q[MsbPos];

endmodule

`default_nettype wire

// ===== hdl/i2cms_phase_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cms_phase_fsm #(
  parameter int BitsPerByte = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  output logic                        cmd_ready_o,
  input  wire i2cms_pkg::cmd_e        func_i,
  input  wire logic                   sda_sample_i,
  input  wire logic                   advance_i,
  input  wire logic                   msb_i,
  output i2cms_pkg::shift_ctrl_t      shift_ctrl_o,
  output logic                        phase_valid_o,
  output i2cms_pkg::phase_t           phase_o
);
  import i2cms_pkg::*;

  localparam int WriteLastPh = 3 * BitsPerByte;
  localparam int PhRawW      = $clog2(WriteLastPh + 1);
  localparam int PhW         = (PhRawW > 3) ? PhRawW : 3;

  state_e         state_q, state_d;
  logic [PhW-1:0] ph_q, ph_d;
  bit_step_e      step_q, step_d;
  logic           nack_q;
  logic           scl_q, sda_q, drv_q;
  logic           accept;
  logic           step_en;
  logic           last;
  logic           shift_req;
  phase_t         phase;

  assign cmd_ready_o   = (state_q == ST_IDLE);
  assign accept        = cmd_valid_i && cmd_ready_o;
  assign phase_valid_o = (state_q != ST_IDLE);
  assign step_en       = phase_valid_o && advance_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            CMD_START: state_d = ST_START;
            CMD_WRITE: state_d = ST_WRITE;
            CMD_ACK:   state_d = ST_ACK;
            CMD_STOP:  state_d = ST_STOP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      default: begin
        if (step_en && last) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Pin levels after the current phase, and the shift request.
  always_comb begin
    phase           = '0;
    phase.scl_level = scl_q;
    phase.sda_level = sda_q;
    phase.sda_drive = drv_q;
    last            = 1'b0;
    shift_req       = 1'b0;
    case (state_q)
      ST_START: begin
        if (ph_q == PhW'(0)) begin
          phase.sda_drive = 1'b1;
        end else if (ph_q == PhW'(1)) begin
          phase.sda_level = 1'b0;
        end else begin
          phase.scl_level = 1'b0;
          last            = 1'b1;
        end
      end
      ST_WRITE: begin
        if (ph_q == PhW'(0)) begin
          phase.sda_drive = 1'b1;
          phase.sda_level = msb_i;
          shift_req       = 1'b1;
        end else if (ph_q == PhW'(WriteLastPh)) begin
          phase.sda_drive = 1'b0;
          last            = 1'b1;
        end else begin
          case (step_q)
            BIT_HIGH: phase.scl_level = 1'b1;
            BIT_LOW:  phase.scl_level = 1'b0;
            BIT_LOAD: begin
              phase.sda_level = msb_i;
              shift_req       = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (ph_q == PhW'(0)) begin
          phase.scl_level = 1'b1;
        end else begin
          phase.scl_level = 1'b0;
          phase.nack      = nack_q;
          last            = 1'b1;
        end
      end
      ST_STOP: begin
        if (ph_q == PhW'(0)) begin
          phase.sda_drive = 1'b1;
        end else if (ph_q == PhW'(1)) begin
          phase.sda_level = 1'b1;
        end else if (ph_q == PhW'(2)) begin
          phase.sda_level = 1'b0;
        end else if (ph_q == PhW'(3)) begin
          phase.scl_level = 1'b1;
        end else begin
          phase.sda_drive = 1'b0;
          last            = 1'b1;
        end
      end
      default: ;
    endcase
    phase.last = last;
  end

  assign phase_o            = phase;
  assign shift_ctrl_o.load  = accept && (func_i == CMD_WRITE);
  assign shift_ctrl_o.shift = step_en && shift_req;

  // Phase index and bit step counters.
  always_comb begin
    ph_d   = ph_q;
    step_d = step_q;
    if (accept) begin
      ph_d   = '0;
      step_d = BIT_HIGH;
    end else if (step_en) begin
      ph_d = last ? '0 : ph_q + PhW'(1);
      if (ph_q != PhW'(0)) begin
        case (step_q)
          BIT_HIGH: step_d = BIT_LOW;
          BIT_LOW:  step_d = BIT_LOAD;
          default:  step_d = BIT_HIGH;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= '0;
      step_q  <= BIT_HIGH;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      step_q  <= step_d;
      if (step_en) begin
        scl_q <= phase.scl_level;
        sda_q <= phase.sda_level;
        drv_q <= phase.sda_drive;
      end
    end
  end

  // Acknowledge sample is held for the final phase of the check.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      nack_q <= sda_sample_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit up)                        tuser / tlast
// s_axis    in   data_byte[7:0], sda_sample[8], zero fill   tuser: func[1:0]
// m_axis    out  scl_level, sda_level, sda_drive, nack      tlast: last
//
// One word in is one command; one word out is one pin phase.
// A command is accepted, then its pin phases follow in order; on a write the
// phase sequencer steps the shift register one bit per data bit, loading the
// byte when the write command is accepted.
// A stalled output holds the sequencer; the next command is taken once the
// last phase has moved into the output register.
// Reset leaves SCL and SDA high, SDA released, and the block idle.
module i2c_master_bit_sequencer #(
  parameter int BITS_PER_BYTE = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // data_byte[7:0], sda_sample[8], zeros above
  input  wire logic [i2cms_pkg::InDataW-1:0]     s_axis_tdata,
  // func[1:0]
  input  wire logic [i2cms_pkg::InUserW-1:0]     s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], nack[3], zeros above
  output logic [i2cms_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import i2cms_pkg::*;

  shift_ctrl_t shift_ctrl;
  logic        msb;
  logic        advance;
  logic        phase_valid;
  phase_t      phase;
  logic        out_valid_q, out_valid_d;
  phase_t      out_q;

  i2cms_shifter u_shifter (
    .clk_i       (clk_i),
    .ctrl_i      (shift_ctrl),
    .data_byte_i (s_axis_tdata[ByteW-1:0]),
    .msb_o       (msb)
  );

  i2cms_phase_fsm #(
    .BitsPerByte (BITS_PER_BYTE)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_o   (s_axis_tready),
    .func_i        (cmd_e'(s_axis_tuser)),
    .sda_sample_i  (s_axis_tdata[ByteW]),
    .advance_i     (advance),
    .msb_i         (msb),
    .shift_ctrl_o  (shift_ctrl),
    .phase_valid_o (phase_valid),
    .phase_o       (phase)
  );

  // Output register: a phase moves in when the slot is empty or draining.
  assign advance = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = phase_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && phase_valid) begin
      out_q <= phase;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {{(OutDataW - OutFieldW){1'b0}},
                          out_q.nack, out_q.sda_drive, out_q.sda_level, out_q.scl_level};

  // A command in flight blocks the input side.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again while a command is in flight");

  a_no_accept_while_phasing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_valid |-> !s_axis_tready)
    else $error("input ready while phases remain");

  // No-acknowledge only appears on the final phase of a command.
  a_nack_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tlast)
    else $error("nack set on a phase that is not the last");

endmodule

`default_nettype wire

// ===== dv/tb_i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer;

  import i2cms_pkg::*;

  localparam int BitsPerByte = 8;
  localparam int RandCmds    = 140;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // data_byte[7:0], sda_sample[8], zeros above
  logic [InDataW-1:0]  s_axis_tdata;
  // func[1:0]
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // scl_level[0], sda_level[1], sda_drive[2], nack[3], zeros above
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  // Pin levels as the sequencer should hold them between commands.
  logic            bus_scl;
  logic            bus_sda;
  logic            bus_drv;
  logic [ByteW-1:0] tx_shift;

  // Pin phases still owed by the block, oldest first.
  phase_t pin_phase_q[$];

  int  err_cnt;
  bit  src_steady;
  bit  sink_steady;

  i2c_master_bit_sequencer #(
    .BITS_PER_BYTE(BitsPerByte)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("i2c_master_bit_sequencer regression: fail");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Record one phase with the current pin levels.
  function automatic void push_phase(logic nack, logic last);
    phase_t ph;
    ph.scl_level = bus_scl;
    ph.sda_level = bus_sda;
    ph.sda_drive = bus_drv;
    ph.nack      = nack;
    ph.last      = last;
    pin_phase_q.push_back(ph);
  endfunction

  // Put the next transmit bit on the data latch, MSB first.
  function automatic void next_tx_bit();
    bus_sda  = tx_shift[MsbPos];
    tx_shift = tx_shift << 1;
  endfunction

  // Work out every pin phase that one command produces.
  function automatic void predict_pins(cmd_e func, logic [ByteW-1:0] data_byte,
                                       logic sda_sample);
    int i;
    case (func)
      CMD_START: begin
        bus_drv = 1'b1;
        push_phase(1'b0, 1'b0);
        bus_sda = 1'b0;
        push_phase(1'b0, 1'b0);
        bus_scl = 1'b0;
        push_phase(1'b0, 1'b1);
      end
      CMD_WRITE: begin
        tx_shift = data_byte;
        bus_drv  = 1'b1;
        next_tx_bit();
        push_phase(1'b0, 1'b0);
        for (i = 0; i < BitsPerByte; i++) begin
          bus_scl = 1'b1;
          push_phase(1'b0, 1'b0);
          bus_scl = 1'b0;
          push_phase(1'b0, 1'b0);
          if (i + 1 < BitsPerByte) begin
            next_tx_bit();
            push_phase(1'b0, 1'b0);
          end
        end
        bus_drv = 1'b0;
        push_phase(1'b0, 1'b1);
      end
      CMD_ACK: begin
        bus_scl = 1'b1;
        push_phase(1'b0, 1'b0);
        bus_scl = 1'b0;
        push_phase(sda_sample, 1'b1);
      end
      default: begin
        bus_drv = 1'b1;
        push_phase(1'b0, 1'b0);
        bus_sda = 1'b1;
        push_phase(1'b0, 1'b0);
        bus_sda = 1'b0;
        push_phase(1'b0, 1'b0);
        bus_scl = 1'b1;
        push_phase(1'b0, 1'b0);
        bus_drv = 1'b0;
        push_phase(1'b0, 1'b1);
      end
    endcase
  endfunction

  // Offer one command word and wait until the block takes it.
  task automatic send_command(cmd_e func, logic [ByteW-1:0] data_byte, logic sda_sample);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, sda_sample, data_byte};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pins(func, data_byte, sda_sample);
  endtask

  // Drop valid right after an accept and let every owed phase come out.
  task automatic drain_phases();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pin_phase_q.size() != 0) @(posedge clk_i);
  endtask

  // Random back-pressure from the receiving side.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      err_cnt++;
    end
  endfunction

  // Compare each phase word that leaves the block with the oldest prediction.
  always @(posedge clk_i) begin
    phase_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pin_phase_q.size() == 0) begin
        $error("phase word with none expected: tdata %02h, tlast %0b",
               m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        want = pin_phase_q.pop_front();
        check_field("scl_level", want.scl_level, m_axis_tdata[0]);
        check_field("sda_level", want.sda_level, m_axis_tdata[1]);
        check_field("sda_drive", want.sda_drive, m_axis_tdata[2]);
        check_field("nack", want.nack, m_axis_tdata[3]);
        check_field("last", want.last, m_axis_tlast);
        if (m_axis_tdata[OutDataW-1:OutFieldW] !== '0) begin
          $error("tdata fill: expected 0, actual %0h", m_axis_tdata[OutDataW-1:OutFieldW]);
          err_cnt++;
        end
      end
    end
  end

  // Start and stop straight out of reset, with the lines idle.
  task automatic test_idle_start_stop();
    send_command(CMD_START, 8'h00, 1'b0);
    send_command(CMD_STOP, 8'hFF, 1'b1);
  endtask

  // Byte writes at the data extremes, each answered with ack or nack.
  task automatic test_write_extremes();
    send_command(CMD_START, 8'h00, 1'b0);
    send_command(CMD_WRITE, 8'h00, 1'b0);
    send_command(CMD_ACK, 8'h00, 1'b0);
    send_command(CMD_WRITE, 8'hFF, 1'b1);
    send_command(CMD_ACK, 8'hFF, 1'b1);
    send_command(CMD_WRITE, 8'h80, 1'b0);
    send_command(CMD_ACK, 8'h80, 1'b0);
    send_command(CMD_WRITE, 8'h01, 1'b1);
    send_command(CMD_ACK, 8'h01, 1'b0);
    send_command(CMD_WRITE, 8'hA5, 1'b0);
    send_command(CMD_ACK, 8'h5A, 1'b1);
    send_command(CMD_STOP, 8'h00, 1'b0);
  endtask

  // Fixed sequences run from whatever the lines hold, including repeats.
  task automatic test_any_state();
    send_command(CMD_STOP, 8'h00, 1'b1);
    send_command(CMD_STOP, 8'hFF, 1'b0);
    send_command(CMD_ACK, 8'hC3, 1'b1);
    send_command(CMD_START, 8'hFF, 1'b1);
    send_command(CMD_START, 8'h3C, 1'b0);
    send_command(CMD_WRITE, 8'h5A, 1'b1);
    send_command(CMD_STOP, 8'h00, 1'b0);
  endtask

  // Mostly well-formed transfers with random content, some stray commands.
  task automatic test_random_traffic();
    int sent;
    int n_bytes;
    sent = 0;
    while (sent < RandCmds) begin
      if ($urandom_range(0, 9) < 8) begin
        send_command(CMD_START, 8'($urandom), 1'($urandom));
        n_bytes = $urandom_range(1, 4);
        repeat (n_bytes) begin
          send_command(CMD_WRITE, 8'($urandom), 1'($urandom));
          send_command(CMD_ACK, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        send_command(CMD_STOP, 8'($urandom), 1'($urandom));
        sent += 2 + 2 * n_bytes;
      end else begin
        send_command(cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        sent++;
      end
      // Switch between idling and back-to-back stretches on both sides.
      if ($urandom_range(0, 5) == 0) src_steady = !src_steady;
      if ($urandom_range(0, 5) == 0) sink_steady = !sink_steady;
      if ($urandom_range(0, 11) == 0) drain_phases();
    end
  endtask

  // Sequence of tests.
  initial begin
    err_cnt       = 0;
    src_steady    = 1'b0;
    sink_steady   = 1'b0;
    bus_scl       = 1'b1;
    bus_sda       = 1'b1;
    bus_drv       = 1'b0;
    tx_shift      = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_START;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_start_stop();
    test_write_extremes();
    drain_phases();
    test_any_state();
    test_random_traffic();
    drain_phases();
    repeat (30) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("i2c_master_bit_sequencer regression: pass");
    end else begin
      $display("i2c_master_bit_sequencer regression: fail");
    end
    $finish;
  end

endmodule
